// ----- sv/hcbp_pkg.sv -----
// Shared types and constants for the Huffman code bit packer.
// Used by hcbp_packer and huffman_code_bit_packer; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  localparam int SymbolW    = 8;
  localparam int CodeW      = 32;
  localparam int LenW       = 6;
  localparam int ByteW      = 8;
  localparam int MaxCodeLen = 32;
  // longest code that fits both the limit and the code field
  localparam int LenLimit   = (MaxCodeLen < CodeW) ? MaxCodeLen : CodeW;
  // pending bits (< 8) plus one full code
  localparam int AccW       = CodeW + ByteW;
  localparam int CntW       = 6;
  localparam int InDataW    = 48;
  localparam int FuncW      = 2;
  localparam int StatusW    = 2;
  localparam int OutUserW   = 1 + StatusW;

  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_NO_CODE  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [CodeW-1:0] code;
  } entry_t;

  // one request from the front end to the packer
  typedef struct packed {
    logic    encode;
    logic    err;
    logic    flush;
    status_e status;
  } cmd_t;

endpackage

`default_nettype wire

// ----- sv/hcbp_ram.sv -----
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_ram #(
  parameter int Width = 38,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/hcbp_packer.sv -----
// Bit accumulator, byte emitter and output register of the code bit packer.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_packer
  import hcbp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  input  wire entry_t              rd_entry_i,
  output logic                     busy_o,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [ByteW-1:0]         m_axis_tdata,  // out_byte
  output logic [OutUserW-1:0]      m_axis_tuser,  // byte_valid, status[1:0]
  output logic                     m_axis_tlast
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EMIT = 4'b0100,
    S_ONE  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]   total_q, total_d;

  logic [ByteW-1:0]  one_byte_q, one_byte_d;
  logic              one_bvalid_q, one_bvalid_d;
  status_e           one_status_q, one_status_d;

  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  out_byte_q, out_byte_d;
  logic              out_bvalid_q, out_bvalid_d;
  status_e           out_status_q, out_status_d;
  logic              out_last_q, out_last_d;

  logic              slot_free;
  logic [AccW-1:0]   code_masked;
  logic [AccW-1:0]   merged;
  logic [CntW-1:0]   sum;

  assign slot_free   = !out_valid_q || m_axis_tready;
  assign code_masked = AccW'(rd_entry_i.code) & ~({AccW{1'b1}} << rd_entry_i.len);
  // new code bits land just above the pending ones
  assign merged      = {{(AccW-ByteW){1'b0}}, acc_q[ByteW-1:0]} | (code_masked << total_q[2:0]);
  assign sum         = total_q + rd_entry_i.len;

  always_comb begin
    state_d      = state_q;
    acc_d        = acc_q;
    total_d      = total_q;
    one_byte_d   = one_byte_q;
    one_bvalid_d = one_bvalid_q;
    one_status_d = one_status_q;
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_bvalid_d = out_bvalid_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        priority if (cmd_i.encode) begin
          state_d = S_READ;
        end else if (cmd_i.err) begin
          one_byte_d   = '0;
          one_bvalid_d = 1'b0;
          one_status_d = cmd_i.status;
          state_d      = S_ONE;
        end else if (cmd_i.flush && total_q != '0) begin
          one_byte_d   = acc_q[ByteW-1:0];
          one_bvalid_d = 1'b1;
          one_status_d = ST_OK;
          acc_d        = '0;
          total_d      = '0;
          state_d      = S_ONE;
        end
      end
      S_READ: begin
        acc_d   = merged;
        total_d = sum;
        state_d = (sum >= CntW'(ByteW)) ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_byte_d   = acc_q[ByteW-1:0];
          out_bvalid_d = 1'b1;
          out_status_d = ST_OK;
          out_last_d   = (total_q < CntW'(2*ByteW));
          acc_d        = acc_q >> ByteW;
          total_d      = total_q - CntW'(ByteW);
          if (total_q < CntW'(2*ByteW)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_ONE: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_byte_d   = one_byte_q;
          out_bvalid_d = one_bvalid_q;
          out_status_d = one_status_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    one_byte_q   <= one_byte_d;
    one_bvalid_q <= one_bvalid_d;
    one_status_q <= one_status_d;
    out_byte_q   <= out_byte_d;
    out_bvalid_q <= out_bvalid_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = {out_status_q, out_bvalid_q};
  assign m_axis_tlast  = out_last_q;

  // requests only arrive while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.encode || cmd_i.err || cmd_i.flush) |-> state_q == S_IDLE)
    else $error("packer request while busy");

  // the table read follows an encode request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> $past(cmd_i.encode))
    else $error("table read without encode");

  // fewer than eight bits stay pending between items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> total_q < CntW'(ByteW))
    else $error("full byte left pending");

  // an emitted code byte is a valid ok beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && slot_free) |=>
      (m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[OutUserW-1:1] == ST_OK))
    else $error("emitted byte not flagged valid");

endmodule

`default_nettype wire

// ----- sv/huffman_code_bit_packer.sv -----
// Huffman code bit packer top level: input decode, code table and loaded flags.
// Depends on hcbp_pkg, hcbp_ram and hcbp_packer.
//
// Input beats (s_axis) carry the function in tuser and symbol, code bits and
// code length in tdata. A load beat writes one code table entry and gives no
// output unless its length is too long (status beat). An encode beat reads the
// table, merges the code into the pending bits, then emits one packed byte per
// cycle while the receiver accepts, up to four, the last one tagged with tlast.
// The rate is set by the one-byte output register draining the bit accumulator.
// Output beats (m_axis) carry the packed byte in tdata and byte_valid/status
// in tuser. A stalled receiver holds the current beat in the output register
// and the packer waits; s_axis_tready stays low until the item is finished.
// Reset clears the pending bits, the loaded flags and the output valid; the
// table contents themselves are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_bit_packer
  import hcbp_pkg::*;
#(
  parameter int SYMBOL_COUNT = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // symbol, code_bits, code_length
  input  wire logic [FuncW-1:0]    s_axis_tuser,  // func
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [ByteW-1:0]         m_axis_tdata,  // out_byte
  output logic [OutUserW-1:0]      m_axis_tuser,  // byte_valid, status[1:0]
  output logic                     m_axis_tlast
);

  localparam int SymW    = $clog2(SYMBOL_COUNT);
  localparam int SymCmpW = SymbolW + 1;
  localparam int EntryW  = $bits(entry_t);

  logic [SymbolW-1:0]      sym;
  logic [CodeW-1:0]        code_in;
  logic [LenW-1:0]         len_in;
  logic [SymW-1:0]         sym_idx;
  logic                    accept;
  logic                    is_load, is_encode, is_flush;
  logic                    in_range, too_long, known;
  logic [SYMBOL_COUNT-1:0] loaded_q, loaded_d;
  logic                    tbl_we;
  entry_t                  wr_entry;
  logic [EntryW-1:0]       rd_raw;
  cmd_t                    cmd;
  logic                    busy;

  assign sym     = s_axis_tdata[SymbolW-1:0];
  assign code_in = s_axis_tdata[SymbolW +: CodeW];
  assign len_in  = s_axis_tdata[SymbolW+CodeW +: LenW];
  assign sym_idx = sym[SymW-1:0];

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign is_load   = (s_axis_tuser == FUNC_LOAD);
  assign is_encode = (s_axis_tuser == FUNC_ENCODE);
  assign is_flush  = (s_axis_tuser == FUNC_FLUSH);

  assign in_range = ({1'b0, sym} < SymCmpW'(SYMBOL_COUNT));
  assign too_long = (len_in > LenW'(LenLimit));
  assign known    = in_range && loaded_q[sym_idx];

  assign tbl_we        = accept && is_load && !too_long && in_range;
  assign wr_entry.len  = len_in;
  assign wr_entry.code = code_in;

  always_comb begin
    loaded_d = loaded_q;
    if (tbl_we) begin
      loaded_d[sym_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
    end else begin
      loaded_q <= loaded_d;
    end
  end

  assign cmd.encode = accept && is_encode && known;
  assign cmd.err    = accept && ((is_encode && !known) || (is_load && too_long));
  assign cmd.flush  = accept && is_flush;
  assign cmd.status = is_encode ? ST_NO_CODE : ST_TOO_LONG;

  hcbp_ram #(
    .Width (EntryW),
    .Depth (SYMBOL_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (sym_idx),
    .wdata_i (wr_entry),
    .re_i    (cmd.encode),
    .raddr_i (sym_idx),
    .rdata_o (rd_raw)
  );

  hcbp_packer u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rd_entry_i    (entry_t'(rd_raw)),
    .busy_o        (busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- verif/hcbp_checker.sv -----
// Scoreboard for the Huffman code bit packer: watches both stream channels,
// predicts the output beats from accepted input beats and compares them.
// Depends on hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_checker
  import hcbp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic [FuncW-1:0]    s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [ByteW-1:0]    m_tdata_i,
  input  logic [OutUserW-1:0] m_tuser_i,
  input  logic                m_tlast_i,
  output int                  fail_cnt_o,
  output int                  exp_left_o
);

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    status_e          status;
    logic             last;
  } pack_beat_t;

  pack_beat_t       packed_q[$];
  logic [CodeW-1:0] code_tbl [256];
  logic [LenW-1:0]  len_tbl  [256];
  logic             loaded_tbl [256];
  logic [ByteW-1:0] pend_byte;
  int               pend_cnt;

  task automatic note_fail(input string msg);
    fail_cnt_o++;
    if (fail_cnt_o <= 10) begin
      $display("%0t ns: %s", $realtime, msg);
    end
  endtask

  // Apply one accepted input beat to the shadow table and bit packer.
  task automatic pack_item(input logic [FuncW-1:0] fn, input logic [SymbolW-1:0] sym,
                           input logic [CodeW-1:0] bits, input logic [LenW-1:0] len);
    pack_beat_t res [4];
    pack_beat_t b;
    int         n;
    int         i;
    logic [CodeW-1:0] code;
    int         clen;
    n = 0;
    if (fn == FUNC_LOAD) begin
      if (len > LenLimit) begin
        b = '{out_byte: '0, byte_valid: 1'b0, status: ST_TOO_LONG, last: 1'b1};
        packed_q.push_back(b);
      end else begin
        code_tbl[sym]   = bits;
        len_tbl[sym]    = len;
        loaded_tbl[sym] = 1'b1;
      end
    end else if (fn == FUNC_ENCODE) begin
      if (!loaded_tbl[sym]) begin
        b = '{out_byte: '0, byte_valid: 1'b0, status: ST_NO_CODE, last: 1'b1};
        packed_q.push_back(b);
      end else begin
        code = code_tbl[sym];
        clen = int'(len_tbl[sym]);
        for (i = 0; i < clen; i++) begin
          pend_byte[pend_cnt] = code[i];
          pend_cnt++;
          if (pend_cnt == 8) begin
            res[n] = '{out_byte: pend_byte, byte_valid: 1'b1, status: ST_OK, last: 1'b0};
            n++;
            pend_byte = '0;
            pend_cnt  = 0;
          end
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (i = 0; i < n; i++) packed_q.push_back(res[i]);
      end
    end else if (fn == FUNC_FLUSH) begin
      if (pend_cnt != 0) begin
        b = '{out_byte: pend_byte, byte_valid: 1'b1, status: ST_OK, last: 1'b1};
        packed_q.push_back(b);
        pend_byte = '0;
        pend_cnt  = 0;
      end
    end
  endtask

  task automatic check_beat();
    pack_beat_t e;
    if (packed_q.size() == 0) begin
      note_fail($sformatf("unexpected beat: byte %02h tuser %03b tlast %b",
                          m_tdata_i, m_tuser_i, m_tlast_i));
    end else begin
      e = packed_q.pop_front();
      if (m_tdata_i !== e.out_byte || m_tuser_i[0] !== e.byte_valid ||
          m_tuser_i[2:1] !== e.status || m_tlast_i !== e.last) begin
        note_fail($sformatf({"mismatch: exp byte %02h valid %b status %0d last %b, ",
                             "got byte %02h valid %b status %0d last %b"},
                            e.out_byte, e.byte_valid, e.status, e.last,
                            m_tdata_i, m_tuser_i[0], m_tuser_i[2:1], m_tlast_i));
      end
    end
  endtask

  initial begin
    fail_cnt_o = 0;
    exp_left_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 256; k++) loaded_tbl[k] = 1'b0;
      pend_byte = '0;
      pend_cnt  = 0;
      packed_q.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        pack_item(s_tuser_i, s_tdata_i[7:0], s_tdata_i[39:8], s_tdata_i[45:40]);
      end
      if (m_tvalid_i && m_tready_i) check_beat();
    end
    exp_left_o = packed_q.size();
  end

endmodule

// ----- verif/huffman_code_bit_packer_tb.sv -----
// Top of the Huffman code bit packer testbench: clock, reset, stimulus and verdict.
// Depends on hcbp_pkg, huffman_code_bit_packer and hcbp_checker.
`timescale 1ns / 1ps

module huffman_code_bit_packer_tb;
  import hcbp_pkg::*;

  localparam logic [FuncW-1:0] FuncUnused = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [FuncW-1:0]    s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [ByteW-1:0]    m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                m_axis_tlast;

  int   fail_cnt;
  int   exp_left;
  bit   src_idle_on;
  bit   sink_idle_on;
  bit   hold_req;
  bit   sym_seen [256];
  logic [SymbolW-1:0] loaded_syms[$];

  huffman_code_bit_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  hcbp_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .m_tlast_i  (m_axis_tlast),
    .fail_cnt_o (fail_cnt),
    .exp_left_o (exp_left)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Output side: random back-pressure, plus a long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(sink_idle_on && $urandom_range(99) < 28);
      end
    end
  end

  // tvalid is only lowered when a gap is taken, so it is never toggled twice in a step
  task automatic offer_beat(input logic [FuncW-1:0] fn, input logic [SymbolW-1:0] sym,
                            input logic [CodeW-1:0] bits, input logic [LenW-1:0] len);
    while (src_idle_on && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, len, bits, sym};
    s_axis_tuser  <= fn;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (fn == FUNC_LOAD && len <= LenLimit && !sym_seen[sym]) begin
      sym_seen[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (exp_left != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic random_items(input int count);
    int                 r;
    logic [SymbolW-1:0] sym;
    logic [LenW-1:0]    len;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 14 || loaded_syms.size() == 0) begin
        sym = SymbolW'($urandom_range(255));
        if ($urandom_range(9) == 0) len = LenW'($urandom_range(63, 33));
        else if ($urandom_range(3) == 0) len = LenW'($urandom_range(32));
        else len = LenW'($urandom_range(12, 1));
        offer_beat(FUNC_LOAD, sym, $urandom, len);
      end else if (r < 84) begin
        if ($urandom_range(19) == 0) sym = SymbolW'($urandom_range(255));
        else sym = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
        offer_beat(FUNC_ENCODE, sym, $urandom, LenW'($urandom_range(63)));
      end else if (r < 96) begin
        offer_beat(FUNC_FLUSH, SymbolW'($urandom_range(255)), $urandom,
                   LenW'($urandom_range(63)));
      end else begin
        offer_beat(FuncUnused, SymbolW'($urandom_range(255)), $urandom,
                   LenW'($urandom_range(63)));
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;
    hold_req      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, zero-length code, full-width codes, rejects, flushes
    offer_beat(FUNC_ENCODE, 8'd5, '0, '0);
    offer_beat(FUNC_FLUSH, 8'd0, '0, '0);
    offer_beat(FuncUnused, 8'hAA, 32'h5555_AAAA, 6'h2A);
    offer_beat(FUNC_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd0);
    offer_beat(FUNC_ENCODE, 8'd0, '0, '0);
    offer_beat(FUNC_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
    offer_beat(FUNC_ENCODE, 8'd255, '0, '0);
    offer_beat(FUNC_LOAD, 8'd2, 32'h0000_0005, 6'd3);
    offer_beat(FUNC_LOAD, 8'd2, 32'hDEAD_BEEF, 6'd33);  // rejected, entry 2 kept
    offer_beat(FUNC_LOAD, 8'd9, 32'h0000_0000, 6'd63);
    offer_beat(FUNC_LOAD, 8'd1, 32'hA5C3_0F81, 6'd32);
    offer_beat(FUNC_ENCODE, 8'd2, '0, '0);
    offer_beat(FUNC_ENCODE, 8'd1, '0, '0);
    offer_beat(FUNC_LOAD, 8'd3, 32'h0000_0001, 6'd1);
    offer_beat(FUNC_ENCODE, 8'd3, '0, '0);
    offer_beat(FUNC_ENCODE, 8'd3, '0, '0);
    offer_beat(FUNC_FLUSH, 8'd0, '0, '0);
    offer_beat(FUNC_FLUSH, 8'd0, '0, '0);
    offer_beat(FUNC_LOAD, 8'd128, 32'h0000_00C3, 6'd8);
    offer_beat(FUNC_ENCODE, 8'd128, '0, '0);
    offer_beat(FUNC_ENCODE, 8'd3, '0, '0);
    offer_beat(FUNC_ENCODE, 8'd9, '0, '0);               // unloaded, pending kept
    offer_beat(FUNC_ENCODE, 8'd1, '0, '0);
    offer_beat(FUNC_FLUSH, 8'd0, '0, '0);
    wait_drained();

    random_items(100);
    wait_drained();

    // no gaps on either side
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    random_items(80);
    wait_drained();

    // receiver stalls for a long stretch while random items keep being offered
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    hold_req     = 1'b1;
    random_items(100);
    wait_drained();

    if (fail_cnt == 0) begin
      $display("huffman_code_bit_packer_tb: PASS");
    end else begin
      $display("huffman_code_bit_packer_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("huffman_code_bit_packer_tb: FAIL");
    $finish;
  end

endmodule
